/* sv/vmcs_pkg.sv */
package vmcs_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_WORD_BITS   = 16;

   localparam int PROMPT_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int TICKS_W    = 8;
   localparam int RST_TICKS_W = 4;

   // action codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_PUSH = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_TICKS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TICKS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_TICKS = 2'd3;

   localparam logic [TICKS_W-1:0]     RST_START_TICKS = 8'd5;
   localparam logic [TICKS_W-1:0]     RST_STOP_TICKS  = 8'd84;
   localparam logic [RST_TICKS_W-1:0] RST_RESET_TICKS = 4'd4;

   typedef struct packed {
      logic                is_push;
      logic [PROMPT_W-1:0] prompt;
      logic                busy;
   } cmd_type;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic module_reset_level;
      logic playing;
      logic fast_tick;
      logic dropped;
   } result_type;

   typedef struct packed {
      logic push;
      logic pop;
   } pq_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } pq_stat_type;

endpackage

/* sv/vmcs_if.sv */
interface vmcs_req_if import vmcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [PROMPT_W-1:0] prompt;
   logic                busy_req;

   modport source (output valid, action, prompt, busy_req, input ready);
   modport sink   (input valid, action, prompt, busy_req, output ready);
endinterface

interface vmcs_rsp_if import vmcs_pkg::*; ();
   logic valid;
   logic ready;
   logic clock_level;
   logic data_level;
   logic module_reset_level;
   logic playing;
   logic fast_tick;
   logic dropped;

   modport source (output valid, clock_level, data_level, module_reset_level, playing,
                   fast_tick, dropped, input ready);
   modport sink   (input valid, clock_level, data_level, module_reset_level, playing,
                   fast_tick, dropped, output ready);
endinterface

interface vmcs_csr_if import vmcs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/vmcs_ram.sv */
module vmcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/vmcs_front.sv */
module vmcs_front import vmcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   vmcs_req_if.sink     req_ch,
   output logic         cmd_valid,
   input  logic         cmd_ready,
   output cmd_type      cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       take, give;
   cmd_type    decoded;

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign take         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (cnt_ff != 2'd0);
   assign give         = cmd_valid && cmd_ready;
   assign cmd          = slot_ff[rd_ptr_ff];

   // classify: keep the prompt only for pushes, the busy level only for ticks
   always_comb begin
      decoded.is_push = (req_ch.action == ACT_PUSH);
      decoded.prompt  = decoded.is_push ? req_ch.prompt : '0;
      decoded.busy    = decoded.is_push ? 1'b0 : req_ch.busy_req;
   end

   always_comb begin
      wr_ptr_in = take ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = give ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, take} - {1'b0, give};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

/* sv/vmcs_pqueue.sv */
module vmcs_pqueue import vmcs_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH,
   parameter int WIDTH = DEF_WORD_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  pq_ctl_type       ctl,
   input  logic [WIDTH-1:0] push_data,
   output pq_stat_type      stat,
   output logic [WIDTH-1:0] head
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             hit_ff, hit_in;
   logic [WIDTH-1:0] byp_ff;
   logic [WIDTH-1:0] rd_data;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (ctl.pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(ctl.push) - CW'(ctl.pop);
      // the RAM returns old data when written and read at the same edge
      hit_in   = ctl.push && (wr_ptr_ff == rd_ptr_in);
   end

   vmcs_ram #(
      .WIDTH (WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_in),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         hit_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_ff <= push_data;
   end

   assign head       = hit_ff ? byp_ff : rd_data;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));

endmodule

/* sv/vmcs_back.sv */
module vmcs_back import vmcs_pkg::*; #(
   parameter int WORD_BITS = DEF_WORD_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  cmd_type              cmd,
   output pq_ctl_type           pq_ctl,
   output logic [WORD_BITS-1:0] pq_push_data,
   input  pq_stat_type          pq_stat,
   input  logic [WORD_BITS-1:0] pq_head,
   vmcs_csr_if.sink             csr_ch,
   vmcs_rsp_if.source           rsp_ch
);

   localparam int BW = $clog2(WORD_BITS + 1);
   localparam logic [BW-1:0] BITS_LAST = BW'(WORD_BITS);

   localparam logic [2:0] PH_RESET     = 3'd0;
   localparam logic [2:0] PH_RESETWAIT = 3'd1;
   localparam logic [2:0] PH_PAUSE     = 3'd2;
   localparam logic [2:0] PH_START     = 3'd3;
   localparam logic [2:0] PH_DATA      = 3'd4;
   localparam logic [2:0] PH_STOP      = 3'd5;

   logic                   mute_ff, mute_in;
   logic [TICKS_W-1:0]     start_ticks_ff, start_ticks_in;
   logic [TICKS_W-1:0]     stop_ticks_ff, stop_ticks_in;
   logic [RST_TICKS_W-1:0] reset_ticks_ff, reset_ticks_in;

   logic [2:0]             phase_ff, phase_in;
   logic [WORD_BITS-1:0]   shift_ff, shift_in;
   logic [BW-1:0]          bits_ff, bits_in;
   logic [TICKS_W-1:0]     cd_ff, cd_in;
   logic [RST_TICKS_W-1:0] rc_ff, rc_in;
   logic                   clk_ff, clk_in;
   logic                   dat_ff, dat_in;
   logic                   mr_ff, mr_in;
   logic                   fast_ff, fast_in;
   logic                   active_ff, active_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_data_ff, rsp_data_in;

   logic                   fire;
   logic                   csr_fire;

   assign cmd_ready    = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = cmd_valid && cmd_ready;
   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid;
   assign pq_push_data = WORD_BITS'(cmd.prompt);

   always_comb begin
      logic                 run;
      logic [2:0]           ph_v;
      logic [TICKS_W-1:0]   cd_v;
      logic [TICKS_W-1:0]   cd_d;
      logic [BW-1:0]        bits_v;
      logic                 dropped_v;

      run       = 1'b0;
      ph_v      = phase_ff;
      cd_v      = cd_ff;
      cd_d      = '0;
      bits_v    = bits_ff;
      dropped_v = 1'b0;

      mute_in        = mute_ff;
      start_ticks_in = start_ticks_ff;
      stop_ticks_in  = stop_ticks_ff;
      reset_ticks_in = reset_ticks_ff;
      phase_in       = phase_ff;
      shift_in       = shift_ff;
      bits_in        = bits_ff;
      cd_in          = cd_ff;
      rc_in          = rc_ff;
      clk_in         = clk_ff;
      dat_in         = dat_ff;
      mr_in          = mr_ff;
      fast_in        = fast_ff;
      active_in      = active_ff;
      pq_ctl.push    = 1'b0;
      pq_ctl.pop     = 1'b0;

      if (fire) begin
         if (cmd.is_push) begin
            if (!mute_ff) begin
               if (pq_stat.full) begin
                  dropped_v = 1'b1;
               end else begin
                  pq_ctl.push = 1'b1;
                  active_in   = 1'b1;
               end
            end
         end else if (active_ff) begin
            run = 1'b1;
            if (phase_ff == PH_PAUSE) begin
               if (pq_stat.empty) begin
                  // nothing queued: go quiet until the next push
                  active_in = 1'b0;
                  run       = 1'b0;
               end else begin
                  shift_in   = pq_head;
                  pq_ctl.pop = 1'b1;
                  cd_v       = start_ticks_ff;
                  ph_v       = PH_START;
               end
            end
         end

         if (run) begin
            phase_in = ph_v;
            unique case (ph_v)
               PH_START: begin
                  clk_in = 1'b0;
                  cd_d   = (cd_v != '0) ? cd_v - 1'b1 : '0;
                  cd_in  = cd_d;
                  if (cd_d == '0) begin
                     phase_in = PH_DATA;
                  end
               end
               PH_DATA: begin
                  if (!clk_ff) begin
                     dat_in   = shift_ff[WORD_BITS-1];
                     shift_in = {shift_ff[WORD_BITS-2:0], 1'b0};
                     bits_v   = bits_ff + 1'b1;
                     clk_in   = 1'b1;
                  end else begin
                     clk_in = 1'b0;
                     dat_in = 1'b0;
                  end
                  if (bits_v >= BITS_LAST) begin
                     bits_in  = '0;
                     cd_in    = stop_ticks_ff;
                     phase_in = PH_STOP;
                  end else begin
                     bits_in = bits_v;
                  end
               end
               PH_STOP: begin
                  dat_in = 1'b0;
                  clk_in = 1'b1;
                  cd_d   = (cd_v != '0) ? cd_v - 1'b1 : '0;
                  cd_in  = cd_d;
                  if (cd_d == '0 && !cmd.busy) begin
                     phase_in = PH_PAUSE;
                  end
               end
               PH_RESET: begin
                  if (rc_ff != '0) begin
                     mr_in  = 1'b0;
                     dat_in = 1'b0;
                     clk_in = 1'b1;
                     rc_in  = rc_ff - 1'b1;
                  end else begin
                     phase_in = PH_RESETWAIT;
                  end
               end
               PH_RESETWAIT: begin
                  mr_in = 1'b1;
                  if (!cmd.busy) begin
                     phase_in = PH_PAUSE;
                     fast_in  = 1'b1;
                  end
               end
               default: begin
                  phase_in = PH_PAUSE;
               end
            endcase
         end
      end

      rsp_data_in.clock_level        = clk_in;
      rsp_data_in.data_level         = dat_in;
      rsp_data_in.module_reset_level = mr_in;
      rsp_data_in.playing            = active_in;
      rsp_data_in.fast_tick          = fast_in;
      rsp_data_in.dropped            = dropped_v;

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_fire) begin
         unique case (csr_ch.index)
            CSR_MUTE:        mute_in        = csr_ch.data[0];
            CSR_START_TICKS: start_ticks_in = csr_ch.data[TICKS_W-1:0];
            CSR_STOP_TICKS:  stop_ticks_in  = csr_ch.data[TICKS_W-1:0];
            CSR_RESET_TICKS: begin
               reset_ticks_in = csr_ch.data[RST_TICKS_W-1:0];
               if (phase_ff == PH_RESET) begin
                  rc_in = csr_ch.data[RST_TICKS_W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff        <= 1'b0;
         start_ticks_ff <= RST_START_TICKS;
         stop_ticks_ff  <= RST_STOP_TICKS;
         reset_ticks_ff <= RST_RESET_TICKS;
         phase_ff       <= PH_RESET;
         shift_ff       <= '0;
         bits_ff        <= '0;
         cd_ff          <= RST_START_TICKS;
         rc_ff          <= RST_RESET_TICKS;
         clk_ff         <= 1'b0;
         dat_ff         <= 1'b0;
         mr_ff          <= 1'b1;
         fast_ff        <= 1'b0;
         active_ff      <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mute_ff        <= mute_in;
         start_ticks_ff <= start_ticks_in;
         stop_ticks_ff  <= stop_ticks_in;
         reset_ticks_ff <= reset_ticks_in;
         phase_ff       <= phase_in;
         shift_ff       <= shift_in;
         bits_ff        <= bits_in;
         cd_ff          <= cd_in;
         rc_ff          <= rc_in;
         clk_ff         <= clk_in;
         dat_ff         <= dat_in;
         mr_ff          <= mr_in;
         fast_ff        <= fast_in;
         active_ff      <= active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.clock_level        = rsp_data_ff.clock_level;
   assign rsp_ch.data_level         = rsp_data_ff.data_level;
   assign rsp_ch.module_reset_level = rsp_data_ff.module_reset_level;
   assign rsp_ch.playing            = rsp_data_ff.playing;
   assign rsp_ch.fast_tick          = rsp_data_ff.fast_tick;
   assign rsp_ch.dropped            = rsp_data_ff.dropped;

endmodule

/* sv/voice_module_command_sender.sv */
// Channel   Dir  Handshake        Carries
// req_ch    in   valid / ready    action, prompt, busy_req
// rsp_ch    out  valid / ready    clock_level, data_level, module_reset_level,
//                                 playing, fast_tick, dropped
// csr_ch    in   valid / ready    index, data (register write, always ready)
//
// One item per clock sustained while rsp_ready is high, tick or push alike;
// an item waits in a front queue slot, and its result in the result register.
// The back end does each item's whole state update as it takes it; the prompt
// queue RAM is read at the next read pointer, with a bypass for a word just written.
// Reset is synchronous and needs no clearing pass over the prompt RAM.
// A two-entry queue after the input lets up to two items wait while rsp_ready
// is low; req_ready drops only when both entries are taken.
module voice_module_command_sender import vmcs_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int WORD_BITS   = DEF_WORD_BITS
) (
   input  logic        clock,
   input  logic        reset,
   vmcs_req_if.sink    req_ch,
   vmcs_rsp_if.source  rsp_ch,
   vmcs_csr_if.sink    csr_ch
);

   logic                 cmd_valid;
   logic                 cmd_ready;
   cmd_type              cmd;
   pq_ctl_type           pq_ctl;
   pq_stat_type          pq_stat;
   logic [WORD_BITS-1:0] pq_push_data;
   logic [WORD_BITS-1:0] pq_head;

   vmcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   vmcs_pqueue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (WORD_BITS)
   ) u_pqueue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (pq_ctl),
      .push_data (pq_push_data),
      .stat      (pq_stat),
      .head      (pq_head)
   );

   vmcs_back #(
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .pq_ctl       (pq_ctl),
      .pq_push_data (pq_push_data),
      .pq_stat      (pq_stat),
      .pq_head      (pq_head),
      .csr_ch       (csr_ch),
      .rsp_ch       (rsp_ch)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(pq_ctl.push && pq_stat.full))
      else $error("prompt pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pq_ctl.pop && pq_stat.empty))
      else $error("prompt popped from an empty queue");

   a_cmd_holds: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
      else $error("queued item changed while the back end stalled");

   a_fast_after_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.module_reset_level |-> !rsp_ch.fast_tick)
      else $error("fast tick raised while module held in reset");
`endif

endmodule
